[hw/rtl/isc_pkg.sv]
package isc_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int MAX_ORDER_DEF = 15;

    // Log-domain values: signed, 32 fraction bits, wide enough for the
    // largest sum of step, history and gain terms.
    localparam int LOG_W   = 48;
    localparam int LOG_ONE_SH = 32;
    // Gain product |k*log| fits 56 bits; after the Q2.14 scale the
    // dividend for the division by the order fits DIV_W bits.
    localparam int DIV_W   = 42;
    localparam int PROD_W  = 80;
    localparam int GAIN_W  = 16;
    localparam int ORD_W   = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] KIND_ESTIMATE = 2'd0;
    localparam logic [1:0] KIND_UPDATE   = 2'd1;
    localparam logic [1:0] KIND_RESTART  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_EXPLICIT_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_EXPLICIT_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_IMPLICIT_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_IMPLICIT_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_BIAS           = 3'd4;

    localparam logic [GAIN_W-1:0] RST_GAIN_EXPLICIT_FIRST  = 16'd6013;
    localparam logic [GAIN_W-1:0] RST_GAIN_EXPLICIT_SECOND = 16'd4391;
    localparam logic [GAIN_W-1:0] RST_GAIN_IMPLICIT_FIRST  = 16'd15565;
    localparam logic [GAIN_W-1:0] RST_GAIN_IMPLICIT_SECOND = 16'd15565;
    localparam logic [GAIN_W-1:0] RST_ERROR_BIAS           = 16'd256;
    localparam logic [GAIN_W-1:0] GAIN_UNITY               = 16'd16384;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOG,
        OP_GAIN,
        OP_EXP,
        OP_UPDATE,
        OP_RESTART,
        OP_SET_MAX,
        OP_SET_ZERO
    } op_t;

    typedef enum logic [2:0] {
        SRC_H,
        SRC_BIAS,
        SRC_DSM,
        SRC_PREV_ERR,
        SRC_PREV_STEP
    } src_t;

    typedef enum logic [2:0] {
        GAIN_ONE,
        GAIN_K1I,
        GAIN_K2I,
        GAIN_K1E,
        GAIN_K2E
    } gsel_t;

    typedef struct packed {
        op_t   op;
        src_t  src;
        gsel_t gsel;
    } cmd_t;

    typedef struct packed {
        logic in_load;
        logic out_load;
    } xfer_t;

    typedef struct packed {
        logic       done;
        logic [1:0] kind;
        logic       first;
        logic       special_max;
        logic       step_zero;
    } status_t;

    // r(k) = floor(sqrt(r(k-1) * 2^31)), r(0) = 2^32: 2^(31 + 2^-k) in Q1.31.
    function automatic logic [31:0][32:0] gen_roots();
        logic [31:0][32:0] tab;
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        r = 64'd1 << 32;
        tab = '0;
        for (int k = 0; k < 32; k++) begin
            v = r << 31;
            res = 64'd0;
            bitv = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (v >= res + bitv) begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            r = res;
            tab[k] = r[32:0];
        end
        return tab;
    endfunction

    localparam logic [31:0][32:0] EXP_ROOTS = gen_roots();

endpackage

[hw/rtl/isc_ctrl.sv]
module isc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  isc_pkg::status_t status,
    output isc_pkg::cmd_t    cmd,
    output isc_pkg::xfer_t   xfer
);
    import isc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOG_H,
        S_LOG_B,
        S_LOG_D,
        S_LOG_PE,
        S_LOG_PS,
        S_G_ONE,
        S_G_K1I,
        S_G_K2I,
        S_G_K1E,
        S_G_K2E,
        S_EXP,
        S_SPECIAL,
        S_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready      = (state_reg == S_IDLE);
    assign xfer.in_load  = in_valid && in_ready;
    assign xfer.out_load = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    assign out_valid     = out_valid_reg;
    assign cmd           = cmd_reg;

    always_comb begin
        state_next = state_reg;
        cmd_next   = '{op: OP_NONE, src: SRC_H, gsel: GAIN_ONE};
        if (xfer.out_load) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end

        case (state_reg)
            S_IDLE: begin
                if (xfer.in_load) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (status.kind)
                    KIND_ESTIMATE: begin
                        if (status.special_max) begin
                            cmd_next.op = OP_SET_MAX;
                            state_next  = S_SPECIAL;
                        end
                        else if (status.step_zero) begin
                            cmd_next.op = OP_SET_ZERO;
                            state_next  = S_SPECIAL;
                        end
                        else begin
                            cmd_next.op  = OP_LOG;
                            cmd_next.src = SRC_H;
                            state_next   = S_LOG_H;
                        end
                    end
                    KIND_UPDATE: begin
                        cmd_next.op = OP_UPDATE;
                        state_next  = S_WAIT;
                    end
                    KIND_RESTART: begin
                        cmd_next.op = OP_RESTART;
                        state_next  = S_WAIT;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LOG_H: begin
                if (status.done) begin
                    cmd_next.op  = OP_LOG;
                    cmd_next.src = SRC_BIAS;
                    state_next   = S_LOG_B;
                end
            end
            S_LOG_B: begin
                if (status.done) begin
                    cmd_next.op  = OP_LOG;
                    cmd_next.src = SRC_DSM;
                    state_next   = S_LOG_D;
                end
            end
            S_LOG_D: begin
                if (status.done) begin
                    if (status.first) begin
                        cmd_next.op   = OP_GAIN;
                        cmd_next.gsel = GAIN_ONE;
                        state_next    = S_G_ONE;
                    end
                    else begin
                        cmd_next.op  = OP_LOG;
                        cmd_next.src = SRC_PREV_ERR;
                        state_next   = S_LOG_PE;
                    end
                end
            end
            S_LOG_PE: begin
                if (status.done) begin
                    cmd_next.op  = OP_LOG;
                    cmd_next.src = SRC_PREV_STEP;
                    state_next   = S_LOG_PS;
                end
            end
            S_LOG_PS: begin
                if (status.done) begin
                    cmd_next.op   = OP_GAIN;
                    cmd_next.gsel = GAIN_K1I;
                    state_next    = S_G_K1I;
                end
            end
            S_G_K1I: begin
                if (status.done) begin
                    cmd_next.op   = OP_GAIN;
                    cmd_next.gsel = GAIN_K2I;
                    state_next    = S_G_K2I;
                end
            end
            S_G_K2I: begin
                if (status.done) begin
                    cmd_next.op   = OP_GAIN;
                    cmd_next.gsel = GAIN_K1E;
                    state_next    = S_G_K1E;
                end
            end
            S_G_K1E: begin
                if (status.done) begin
                    cmd_next.op   = OP_GAIN;
                    cmd_next.gsel = GAIN_K2E;
                    state_next    = S_G_K2E;
                end
            end
            S_G_K2E, S_G_ONE: begin
                if (status.done) begin
                    cmd_next.op = OP_EXP;
                    state_next  = S_EXP;
                end
            end
            S_EXP, S_SPECIAL: begin
                if (status.done) begin
                    state_next = S_FINISH;
                end
            end
            S_WAIT: begin
                if (status.done) begin
                    state_next = S_IDLE;
                end
            end
            S_FINISH: begin
                if (xfer.out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '{op: OP_NONE, src: SRC_H, gsel: GAIN_ONE};
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/isc_dp.sv]
module isc_dp #(
    parameter int FRAC_BITS = isc_pkg::FRAC_BITS_DEF,
    parameter int MAX_ORDER = isc_pkg::MAX_ORDER_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  isc_pkg::cmd_t                    cmd,
    input  isc_pkg::xfer_t                   xfer,
    output isc_pkg::status_t                 status,
    input  logic                             cfg_we,
    input  logic [isc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [isc_pkg::GAIN_W-1:0]       cfg_data,
    input  logic [1:0]                       kind,
    input  logic [63:0]                      step_size,
    input  logic [3:0]                       method_order,
    input  logic [63:0]                      error_norm,
    output logic [63:0]                      new_step,
    output logic                             saturated
);
    import isc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_NORM,
        PH_SQ,
        PH_MUL,
        PH_DIV,
        PH_EXP
    } phase_t;

    localparam logic signed [LOG_W-1:0] EXP_BIAS = LOG_W'(FRAC_BITS) <<< LOG_ONE_SH;
    localparam logic signed [LOG_W-1:0] EXP_HI   = LOG_W'(64) <<< LOG_ONE_SH;
    localparam logic signed [LOG_W-1:0] EXP_LO   = -(LOG_W'(40) <<< LOG_ONE_SH);
    localparam logic [63:0] ONE_FIX = 64'd1 << FRAC_BITS;

    // control and architectural state
    phase_t phase_reg, phase_next;
    logic [5:0] cnt_reg, cnt_next;
    logic done_reg, done_next;
    logic [GAIN_W-1:0] k1e_reg, k1e_next, k2e_reg, k2e_next;
    logic [GAIN_W-1:0] k1i_reg, k1i_next, k2i_reg, k2i_next;
    logic [GAIN_W-1:0] bias_reg, bias_next;
    logic [63:0] prev_err_reg, prev_err_next, prev_step_reg, prev_step_next;
    logic first_reg, first_next;

    // payload
    logic [1:0] kind_reg, kind_next;
    logic [63:0] h_reg, h_next, dsm_reg, dsm_next;
    logic [ORD_W-1:0] ord_reg, ord_next;
    src_t src_reg, src_next;
    gsel_t gsel_reg, gsel_next;
    logic upd_reg, upd_next;
    logic neg_reg, neg_next;
    logic [63:0] x_reg, x_next;
    logic [5:0] lz_reg, lz_next;
    logic [31:0] z_reg, z_next;
    logic [31:0] frac_reg, frac_next;
    logic signed [LOG_W-1:0] lh_reg, lh_next, le1_reg, le1_next, le2_reg, le2_next;
    logic signed [LOG_W-1:0] li_reg, li_next, lx_reg, lx_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [GAIN_W-1:0] mplier_reg, mplier_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [DIV_W-1:0] dq_reg, dq_next;
    logic [ORD_W-1:0] rem_reg, rem_next;
    logic [32:0] m_reg, m_next;
    logic [31:0] f_reg, f_next;
    logic signed [7:0] i_reg, i_next;
    logic [63:0] res_reg, res_next;
    logic sat_reg, sat_next;
    logic [63:0] out_step_reg, out_step_next;
    logic out_sat_reg, out_sat_next;

    // shared multiplier: log squaring and exp root products
    logic [32:0] mul_a, mul_b;
    logic [65:0] mul_p;
    assign mul_a = (phase_reg == PH_SQ) ? {1'b0, z_reg} : m_reg;
    assign mul_b = (phase_reg == PH_SQ) ? {1'b0, z_reg} : EXP_ROOTS[cnt_reg[4:0]];
    assign mul_p = mul_a * mul_b;

    // normalize: binary search for the leading one, 32/16/8/4/2/1
    logic [5:0] norm_sh;
    logic norm_zero;
    logic [63:0] x_norm;
    logic [5:0] lz_norm;
    assign norm_sh   = 6'(7'd32 >> cnt_reg[2:0]);
    assign norm_zero = (x_reg >> (7'd64 - {1'b0, norm_sh})) == 64'd0;
    assign x_norm    = norm_zero ? (x_reg << norm_sh) : x_reg;
    assign lz_norm   = norm_zero ? (lz_reg + norm_sh) : lz_reg;

    // square step and log result
    logic [32:0] sq;
    logic [31:0] frac_fin;
    logic signed [7:0] log_int;
    logic signed [LOG_W-1:0] log_val;
    assign sq       = mul_p[63:31];
    assign frac_fin = {frac_reg[30:0], sq[32]};
    assign log_int  = $signed({2'b00, ~lz_reg})
                      - ((src_reg == SRC_BIAS) ? 8'sd8 : 8'(FRAC_BITS));
    assign log_val  = {{(LOG_W-40){log_int[7]}}, log_int, frac_fin};

    // shift-add multiply, LSB of the multiplier first
    logic [64:0] add_sum;
    logic [PROD_W-1:0] acc_step;
    assign add_sum  = {1'b0, acc_reg[PROD_W-1:16]}
                      + (mplier_reg[0] ? {1'b0, mcand_reg} : 65'd0);
    assign acc_step = {add_sum, acc_reg[15:1]};

    // restoring divide by the order
    logic [ORD_W:0] trial;
    logic div_ge;
    logic [ORD_W-1:0] rem_step;
    logic [DIV_W-1:0] dq_step;
    logic signed [LOG_W-1:0] gain_q, gain_val;
    assign trial    = {rem_reg, dq_reg[DIV_W-1]};
    assign div_ge   = trial >= {1'b0, ord_reg};
    assign rem_step = div_ge ? ORD_W'(trial - {1'b0, ord_reg}) : trial[ORD_W-1:0];
    assign dq_step  = {dq_reg[DIV_W-2:0], div_ge};
    assign gain_q   = {{(LOG_W-DIV_W){1'b0}}, dq_step};
    assign gain_val = neg_reg ? gain_q : -gain_q;

    // gain operand select
    logic signed [LOG_W-1:0] gain_lg;
    logic [GAIN_W-1:0] gain_k;
    always_comb begin
        case (cmd.gsel)
            GAIN_ONE: begin
                gain_lg = le1_reg;
                gain_k  = GAIN_UNITY;
            end
            GAIN_K1I: begin
                gain_lg = le1_reg;
                gain_k  = k1i_reg;
            end
            GAIN_K2I: begin
                gain_lg = le2_reg;
                gain_k  = k2i_reg;
            end
            GAIN_K1E: begin
                gain_lg = le1_reg;
                gain_k  = k1e_reg;
            end
            GAIN_K2E: begin
                gain_lg = le2_reg;
                gain_k  = k2e_reg;
            end
            default: begin
                gain_lg = le1_reg;
                gain_k  = GAIN_UNITY;
            end
        endcase
    end

    // exp argument and final scaling
    logic signed [LOG_W-1:0] exp_arg, exp_t;
    logic [32:0] m_step;
    logic [63:0] m_wide, exp_res;
    logic [7:0] exp_rs;
    assign exp_arg = first_reg ? li_reg : ((li_reg < lx_reg) ? li_reg : lx_reg);
    assign exp_t   = exp_arg + EXP_BIAS;
    assign m_step  = f_reg[31] ? mul_p[63:31] : m_reg;
    assign m_wide  = {31'b0, m_step};
    assign exp_rs  = 8'(8'sd31 - i_reg);
    always_comb begin
        if (i_reg >= 8'sd31) begin
            exp_res = m_wide << 6'(i_reg - 8'sd31);
        end
        else if (exp_rs >= 8'd64) begin
            exp_res = 64'd0;
        end
        else begin
            exp_res = m_wide >> exp_rs[5:0];
        end
    end

    always_comb begin
        phase_next = phase_reg;  cnt_next = cnt_reg;  done_next = 1'b0;
        k1e_next = k1e_reg;  k2e_next = k2e_reg;  k1i_next = k1i_reg;
        k2i_next = k2i_reg;  bias_next = bias_reg;
        prev_err_next = prev_err_reg;  prev_step_next = prev_step_reg;
        first_next = first_reg;
        kind_next = kind_reg;  h_next = h_reg;  dsm_next = dsm_reg;  ord_next = ord_reg;
        src_next = src_reg;  gsel_next = gsel_reg;  upd_next = upd_reg;  neg_next = neg_reg;
        x_next = x_reg;  lz_next = lz_reg;  z_next = z_reg;  frac_next = frac_reg;
        lh_next = lh_reg;  le1_next = le1_reg;  le2_next = le2_reg;
        li_next = li_reg;  lx_next = lx_reg;
        mcand_next = mcand_reg;  mplier_next = mplier_reg;  acc_next = acc_reg;
        dq_next = dq_reg;  rem_next = rem_reg;
        m_next = m_reg;  f_next = f_reg;  i_next = i_reg;
        res_next = res_reg;  sat_next = sat_reg;
        out_step_next = out_step_reg;  out_sat_next = out_sat_reg;

        if (cfg_we) begin
            case (cfg_index)
                REG_GAIN_EXPLICIT_FIRST:  k1e_next = cfg_data;
                REG_GAIN_EXPLICIT_SECOND: k2e_next = cfg_data;
                REG_GAIN_IMPLICIT_FIRST:  k1i_next = cfg_data;
                REG_GAIN_IMPLICIT_SECOND: k2i_next = cfg_data;
                REG_ERROR_BIAS: bias_next = (cfg_data == '0) ? RST_ERROR_BIAS : cfg_data;
                default: ;
            endcase
        end

        if (xfer.in_load) begin
            kind_next = kind;
            h_next    = step_size;
            dsm_next  = error_norm;
            ord_next  = (method_order > 4'(MAX_ORDER))
                        ? ORD_W'(MAX_ORDER) + 5'd1 : {1'b0, method_order} + 5'd1;
        end

        if (xfer.out_load) begin
            out_step_next = res_reg;
            out_sat_next  = sat_reg;
        end

        case (phase_reg)
            PH_IDLE: begin
                case (cmd.op)
                    OP_LOG: begin
                        src_next = cmd.src;
                        case (cmd.src)
                            SRC_H:         x_next = h_reg;
                            SRC_BIAS:      x_next = {48'd0, bias_reg};
                            SRC_DSM:       x_next = dsm_reg;
                            SRC_PREV_ERR:  x_next = prev_err_reg;
                            SRC_PREV_STEP: x_next = prev_step_reg;
                            default:       x_next = h_reg;
                        endcase
                        lz_next    = 6'd0;
                        cnt_next   = 6'd0;
                        phase_next = PH_NORM;
                    end
                    OP_GAIN: begin
                        gsel_next   = cmd.gsel;
                        neg_next    = gain_lg[LOG_W-1];
                        mcand_next  = 64'(gain_lg[LOG_W-1] ? -gain_lg : gain_lg);
                        mplier_next = gain_k;
                        acc_next    = '0;
                        upd_next    = 1'b0;
                        cnt_next    = 6'd0;
                        phase_next  = PH_MUL;
                    end
                    OP_UPDATE: begin
                        mcand_next  = dsm_reg;
                        mplier_next = bias_reg;
                        acc_next    = '0;
                        upd_next    = 1'b1;
                        cnt_next    = 6'd0;
                        phase_next  = PH_MUL;
                    end
                    OP_EXP: begin
                        if (exp_t >= EXP_HI) begin
                            res_next  = '1;
                            sat_next  = 1'b1;
                            done_next = 1'b1;
                        end
                        else if (exp_t < EXP_LO) begin
                            res_next  = 64'd0;
                            sat_next  = 1'b0;
                            done_next = 1'b1;
                        end
                        else begin
                            m_next     = 33'd1 << 31;
                            f_next     = exp_t[31:0];
                            i_next     = exp_t[39:32];
                            cnt_next   = 6'd0;
                            phase_next = PH_EXP;
                        end
                    end
                    OP_RESTART: begin
                        prev_err_next = ONE_FIX;
                        first_next    = 1'b1;
                        done_next     = 1'b1;
                    end
                    OP_SET_MAX: begin
                        res_next  = '1;
                        sat_next  = 1'b1;
                        done_next = 1'b1;
                    end
                    OP_SET_ZERO: begin
                        res_next  = 64'd0;
                        sat_next  = 1'b0;
                        done_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            PH_NORM: begin
                x_next   = x_norm;
                lz_next  = lz_norm;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd5) begin
                    z_next     = x_norm[63:32];
                    frac_next  = 32'd0;
                    cnt_next   = 6'd0;
                    phase_next = PH_SQ;
                end
            end
            PH_SQ: begin
                z_next    = sq[32] ? sq[32:1] : sq[31:0];
                frac_next = frac_fin;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                    case (src_reg)
                        SRC_H: begin
                            lh_next = log_val;
                            li_next = log_val;
                        end
                        SRC_BIAS:      le1_next = log_val;
                        SRC_DSM:       le1_next = le1_reg + log_val;
                        SRC_PREV_ERR:  le2_next = le1_reg - log_val;
                        SRC_PREV_STEP: begin
                            li_next = (lh_reg <<< 1) - log_val;
                            lx_next = lh_reg;
                        end
                        default: ;
                    endcase
                end
            end
            PH_MUL: begin
                acc_next    = acc_step;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15) begin
                    cnt_next = 6'd0;
                    if (upd_reg) begin
                        // floor(dsm * bias / 256), clip to all ones
                        prev_err_next  = (|acc_step[PROD_W-1:72]) ? '1 : acc_step[71:8];
                        prev_step_next = h_reg;
                        first_next     = 1'b0;
                        done_next      = 1'b1;
                        phase_next     = PH_IDLE;
                    end
                    else begin
                        dq_next    = acc_step[14+DIV_W-1:14];
                        rem_next   = '0;
                        phase_next = PH_DIV;
                    end
                end
            end
            PH_DIV: begin
                dq_next  = dq_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_W - 1)) begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                    if (gsel_reg == GAIN_K1E || gsel_reg == GAIN_K2E) begin
                        lx_next = lx_reg + gain_val;
                    end
                    else begin
                        li_next = li_reg + gain_val;
                    end
                end
            end
            PH_EXP: begin
                m_next   = m_step;
                f_next   = f_reg << 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    res_next   = exp_res;
                    sat_next   = 1'b0;
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= 6'd0;
            done_reg      <= 1'b0;
            k1e_reg       <= RST_GAIN_EXPLICIT_FIRST;
            k2e_reg       <= RST_GAIN_EXPLICIT_SECOND;
            k1i_reg       <= RST_GAIN_IMPLICIT_FIRST;
            k2i_reg       <= RST_GAIN_IMPLICIT_SECOND;
            bias_reg      <= RST_ERROR_BIAS;
            prev_err_reg  <= ONE_FIX;
            prev_step_reg <= 64'd0;
            first_reg     <= 1'b1;
        end
        else begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            k1e_reg       <= k1e_next;
            k2e_reg       <= k2e_next;
            k1i_reg       <= k1i_next;
            k2i_reg       <= k2i_next;
            bias_reg      <= bias_next;
            prev_err_reg  <= prev_err_next;
            prev_step_reg <= prev_step_next;
            first_reg     <= first_next;
        end
    end

    always_ff @(posedge clk) begin
        kind_reg     <= kind_next;
        h_reg        <= h_next;
        dsm_reg      <= dsm_next;
        ord_reg      <= ord_next;
        src_reg      <= src_next;
        gsel_reg     <= gsel_next;
        upd_reg      <= upd_next;
        neg_reg      <= neg_next;
        x_reg        <= x_next;
        lz_reg       <= lz_next;
        z_reg        <= z_next;
        frac_reg     <= frac_next;
        lh_reg       <= lh_next;
        le1_reg      <= le1_next;
        le2_reg      <= le2_next;
        li_reg       <= li_next;
        lx_reg       <= lx_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        acc_reg      <= acc_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        m_reg        <= m_next;
        f_reg        <= f_next;
        i_reg        <= i_next;
        res_reg      <= res_next;
        sat_reg      <= sat_next;
        out_step_reg <= out_step_next;
        out_sat_reg  <= out_sat_next;
    end

    assign status.done        = done_reg;
    assign status.kind        = kind_reg;
    assign status.first       = first_reg;
    assign status.special_max = (dsm_reg == 64'd0)
                                || (!first_reg && (prev_step_reg == 64'd0
                                                   || prev_err_reg == 64'd0));
    assign status.step_zero   = (h_reg == 64'd0);
    assign new_step           = out_step_reg;
    assign saturated          = out_sat_reg;

endmodule

[hw/rtl/imex_step_size_controller.sv]
// Items are handled one at a time: the block takes no new item until the
// current one is finished. The work is serial: the log2 (normalize, then
// squaring, per operand), the bit-serial gain multiply and the divide by
// the order for each gain term.
// Reset: asynchronous active low; gains and bias to defaults, history restored.
module imex_step_size_controller #(
    parameter int FRAC_BITS = isc_pkg::FRAC_BITS_DEF,
    parameter int MAX_ORDER = isc_pkg::MAX_ORDER_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    kind,
    input  logic [63:0]                   step_size,
    input  logic [3:0]                    method_order,
    input  logic [63:0]                   error_norm,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [63:0]                   new_step,
    output logic                          saturated,
    input  logic                          cfg_we,
    input  logic [isc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [isc_pkg::GAIN_W-1:0]    cfg_data
);
    import isc_pkg::*;

    // Controller sequences the work on one item: logs of h, bias, error and (after
    // the first step) the history, four gain terms (one on the first step), then exp2.
    // Datapath holds the operands, the history and the iterative units and
    // reports completion of each command through status.done.
    cmd_t    cmd;
    xfer_t   xfer;
    status_t status;

    isc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .xfer      (xfer)
    );

    isc_dp #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .xfer         (xfer),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .step_size    (step_size),
        .method_order (method_order),
        .error_norm   (error_norm),
        .new_step     (new_step),
        .saturated    (saturated)
    );

    // A saturated item always carries the all-ones step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (new_step == '1))
        else $error("saturated item without all-ones step");

    // Accepting an item makes the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while busy");

    // Loading the output register presents an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        xfer.out_load |=> out_valid)
        else $error("output load without valid");

endmodule
